// ----- rtl/efr_pkg.sv -----
`default_nettype none

package efr_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_RU_MAC    = 3'd0;
    localparam logic [2:0] CFG_DU_MAC    = 3'd1;
    localparam logic [2:0] CFG_OWN_MAC   = 3'd2;
    localparam logic [2:0] CFG_DU_VLAN   = 3'd3;
    localparam logic [2:0] CFG_RU_VLAN   = 3'd4;
    localparam logic [2:0] CFG_PORT_MASK = 3'd5;

    // Ethertypes of interest
    localparam logic [15:0] TPID_8021Q    = 16'h8100;
    localparam logic [15:0] LOOPBACK_TYPE = 16'hAEFE;

    // Byte positions in the frame
    localparam logic [4:0] POS_SRC_MAC     = 5'd6;
    localparam logic [4:0] POS_TYPE_HI     = 5'd12;
    localparam logic [4:0] POS_TYPE_LO     = 5'd13;
    localparam logic [4:0] POS_TCI_HI      = 5'd14;
    localparam logic [4:0] POS_TCI_LO      = 5'd15;
    localparam logic [4:0] POS_PORT_UNTAG  = 5'd19;
    localparam logic [4:0] POS_PORT_TAG    = 5'd23;
    localparam logic [4:0] POS_END_UNTAG   = 5'd21;
    localparam logic [4:0] POS_END_TAG     = 5'd25;
    localparam logic [4:0] POS_MAX         = 5'd31;

    typedef struct packed {
        logic [47:0] ru_mac;
        logic [47:0] du_mac;
        logic [47:0] own_mac;
        logic [11:0] du_vlan_id;
        logic [11:0] ru_vlan_id;
        logic [15:0] port_mask;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       forward;
    } result_t;

    // Octet k of a MAC address, octet 0 first on the wire
    function automatic logic [7:0] mac_octet(input logic [47:0] mac, input logic [2:0] k);
        logic [7:0] oct;
        case (k)
            3'd0:    oct = mac[47:40];
            3'd1:    oct = mac[39:32];
            3'd2:    oct = mac[31:24];
            3'd3:    oct = mac[23:16];
            3'd4:    oct = mac[15:8];
            3'd5:    oct = mac[7:0];
            default: oct = 8'h00;
        endcase
        return oct;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ecpri_fronthaul_frame_filter_rewriter.sv -----
// eCPRI fronthaul frame filter and rewriter. Frame bytes enter one per request and leave one
// per request, through the input register and then the result register; a new byte is
// taken every cycle while the output is not stalled, set by one input register and one result
// register around a single pass of compare and mux logic. Destination and source MACs are
// replaced by du_mac and own_mac, the VLAN ID of a tagged frame by du_vlan_id with its
// priority bits kept. The forward bit comes on the byte marked last (0 on all others);
// bytes of dropped frames are still delivered, rewritten. Write configuration (cfg_ready is
// always high) only while no bytes are in flight.
`default_nettype none

module ecpri_fronthaul_frame_filter_rewriter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic             forward,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    efr_pkg::cfg_t    cfg;
    efr_pkg::result_t result;
    efr_pkg::result_t res_reg;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_vld_reg;
    logic       out_free;
    logic       in_free;
    logic       advance;

    assign cfg_ready = 1'b1;

    efr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Hold a result until taken; the input stage moves when the result stage frees
    assign out_free = !out_vld_reg || !out_stall;
    assign advance  = in_vld_reg && out_free;
    assign in_free  = !in_vld_reg || out_free;
    assign in_stall = !in_free;

    efr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .result  (result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_free)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && in_valid)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_byte  = res_reg.out_byte;
    assign out_last  = res_reg.out_last;
    assign forward   = res_reg.forward;

endmodule

`default_nettype wire

// ----- rtl/efr_cfg_regs.sv -----
`default_nettype none

module efr_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [47:0]   cfg_data,
    output efr_pkg::cfg_t      cfg
);

    efr_pkg::cfg_t cfg_reg;
    efr_pkg::cfg_t cfg_next;

    // Decode the write request; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                efr_pkg::CFG_RU_MAC:    cfg_next.ru_mac     = cfg_data;
                efr_pkg::CFG_DU_MAC:    cfg_next.du_mac     = cfg_data;
                efr_pkg::CFG_OWN_MAC:   cfg_next.own_mac    = cfg_data;
                efr_pkg::CFG_DU_VLAN:   cfg_next.du_vlan_id = cfg_data[11:0];
                efr_pkg::CFG_RU_VLAN:   cfg_next.ru_vlan_id = cfg_data[11:0];
                efr_pkg::CFG_PORT_MASK: cfg_next.port_mask  = cfg_data[15:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/efr_parser.sv -----
`default_nettype none

module efr_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire efr_pkg::cfg_t cfg,
    input  wire logic          advance,
    input  wire logic [7:0]    byte_in,
    input  wire logic          last_in,
    output efr_pkg::result_t   result
);

    logic [4:0] pos_reg,      pos_next;
    logic       tagged_reg,   tagged_next;
    logic [7:0] type_hi_reg,  type_hi_next;
    logic [3:0] vid_hi_reg,   vid_hi_next;
    logic       vid_ok_reg,   vid_ok_next;
    logic       src_ok_reg,   src_ok_next;
    logic       port_sel_reg, port_sel_next;
    logic       hdr_done_reg, hdr_done_next;

    logic [7:0]  ob;
    logic [2:0]  src_k;
    logic [15:0] ethertype;
    logic [11:0] vid;
    logic [4:0]  port_pos;
    logic [4:0]  end_pos;
    logic        fwd;

    assign src_k     = 3'(pos_reg - efr_pkg::POS_SRC_MAC);
    assign ethertype = {type_hi_reg, byte_in};
    assign vid       = {vid_hi_reg, byte_in};

    // Rewrite the byte and update the header checks
    always_comb
    begin
        ob            = byte_in;
        tagged_next   = tagged_reg;
        type_hi_next  = type_hi_reg;
        vid_hi_next   = vid_hi_reg;
        vid_ok_next   = vid_ok_reg;
        src_ok_next   = src_ok_reg;
        port_sel_next = port_sel_reg;
        hdr_done_next = hdr_done_reg;

        if (pos_reg inside {[5'd0:5'd5]})
        begin
            ob = efr_pkg::mac_octet(cfg.du_mac, pos_reg[2:0]);
        end
        else if (pos_reg inside {[5'd6:5'd11]})
        begin
            if (byte_in != efr_pkg::mac_octet(cfg.ru_mac, src_k))
            begin
                src_ok_next = 1'b0;
            end
            ob = efr_pkg::mac_octet(cfg.own_mac, src_k);
        end
        else if (pos_reg == efr_pkg::POS_TYPE_HI)
        begin
            type_hi_next = byte_in;
        end
        else if (pos_reg == efr_pkg::POS_TYPE_LO)
        begin
            if (ethertype == efr_pkg::TPID_8021Q)
            begin
                tagged_next = 1'b1;
            end
            else if (ethertype == efr_pkg::LOOPBACK_TYPE)
            begin
                vid_ok_next = 1'b0;
            end
        end
        else if (tagged_reg && pos_reg == efr_pkg::POS_TCI_HI)
        begin
            vid_hi_next = byte_in[3:0];
            ob          = {byte_in[7:4], cfg.du_vlan_id[11:8]};
        end
        else if (tagged_reg && pos_reg == efr_pkg::POS_TCI_LO)
        begin
            if (vid != cfg.du_vlan_id && vid != cfg.ru_vlan_id)
            begin
                vid_ok_next = 1'b0;
            end
            ob = cfg.du_vlan_id[7:0];
        end

        // Locate the eCPRI port ID and the end of the header
        port_pos = tagged_next ? efr_pkg::POS_PORT_TAG : efr_pkg::POS_PORT_UNTAG;
        end_pos  = tagged_next ? efr_pkg::POS_END_TAG  : efr_pkg::POS_END_UNTAG;
        if (pos_reg == port_pos)
        begin
            port_sel_next = cfg.port_mask[byte_in[3:0]];
        end
        if (pos_reg == end_pos)
        begin
            hdr_done_next = 1'b1;
        end

        fwd = last_in && hdr_done_next && vid_ok_next && src_ok_next && port_sel_next;

        // Advance the position (holding at POS_MAX), or return to the start of a frame
        if (last_in)
        begin
            pos_next      = '0;
            tagged_next   = 1'b0;
            type_hi_next  = '0;
            vid_hi_next   = '0;
            vid_ok_next   = 1'b1;
            src_ok_next   = 1'b1;
            port_sel_next = 1'b0;
            hdr_done_next = 1'b0;
        end
        else if (pos_reg != efr_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 5'd1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            tagged_reg   <= 1'b0;
            type_hi_reg  <= '0;
            vid_hi_reg   <= '0;
            vid_ok_reg   <= 1'b1;
            src_ok_reg   <= 1'b1;
            port_sel_reg <= 1'b0;
            hdr_done_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg      <= pos_next;
            tagged_reg   <= tagged_next;
            type_hi_reg  <= type_hi_next;
            vid_hi_reg   <= vid_hi_next;
            vid_ok_reg   <= vid_ok_next;
            src_ok_reg   <= src_ok_next;
            port_sel_reg <= port_sel_next;
            hdr_done_reg <= hdr_done_next;
        end
    end

    assign result.out_byte = ob;
    assign result.out_last = last_in;
    assign result.forward  = fwd;

endmodule

`default_nettype wire

// ----- rtl/efr_checker.sv -----
`default_nettype none

module efr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  out_byte,
    input wire logic        out_last,
    input wire logic        forward
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_byte) && $stable(out_last) && $stable(forward))
        else $error("stalled result changed");

    // The verdict only rides on the final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && forward |-> out_last)
        else $error("forward set on a byte not marked last");

    // Input back-pressure only comes from a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

    // An accepted byte is followed by a valid result once it has passed the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
        else $error("accepted byte not presented");

endmodule

bind ecpri_fronthaul_frame_filter_rewriter efr_checker u_efr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .forward   (forward)
);

`default_nettype wire

// ----- bench/tb_ecpri_fronthaul_frame_filter_rewriter.sv -----
`default_nettype none

module tb_ecpri_fronthaul_frame_filter_rewriter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 8;
    localparam int PHASE_BYTES = 185;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HDR_UNTAG   = efr_pkg::POS_END_UNTAG + 1;
    localparam int HDR_TAG     = efr_pkg::POS_END_TAG + 1;

    // Indexes past the register list; writes there must be ignored
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_req_t;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        forward;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [47:0] cfg_data = 48'h0;

    ecpri_fronthaul_frame_filter_rewriter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .forward   (forward),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Pending requests, expected rewritten bytes, error count
    frame_req_t         frame_bytes_q[$];
    efr_pkg::result_t   rewritten_q[$];
    int                 errors = 0;
    int                 bytes_queued = 0;
    int                 hold_ticket = 0;

    // Shadow of the filter registers and of the per-frame parse state
    efr_pkg::cfg_t filter_cfg = '0;
    logic [4:0]    frame_pos = 5'd0;
    logic          tagged_frame = 1'b0;
    logic [7:0]    type_hi = 8'h00;
    logic [3:0]    tci_nibble = 4'h0;
    logic          vid_ok = 1'b1;
    logic          src_ok = 1'b1;
    logic          port_ok = 1'b0;
    logic          hdr_done = 1'b0;

    function automatic void clear_frame();
        frame_pos    = 5'd0;
        tagged_frame = 1'b0;
        type_hi      = 8'h00;
        tci_nibble   = 4'h0;
        vid_ok       = 1'b1;
        src_ok       = 1'b1;
        port_ok      = 1'b0;
        hdr_done     = 1'b0;
    endfunction

    function automatic void apply_cfg(input logic [2:0] idx, input logic [47:0] val);
        case (idx)
            efr_pkg::CFG_RU_MAC:    filter_cfg.ru_mac = val;
            efr_pkg::CFG_DU_MAC:    filter_cfg.du_mac = val;
            efr_pkg::CFG_OWN_MAC:   filter_cfg.own_mac = val;
            efr_pkg::CFG_DU_VLAN:   filter_cfg.du_vlan_id = val[11:0];
            efr_pkg::CFG_RU_VLAN:   filter_cfg.ru_vlan_id = val[11:0];
            efr_pkg::CFG_PORT_MASK: filter_cfg.port_mask = val[15:0];
            default: ;
        endcase
    endfunction

    // Rewrite one accepted byte and advance the frame parse
    function automatic efr_pkg::result_t rewrite_byte(input logic [7:0] b, input logic last);
        efr_pkg::result_t r;
        int               pos;
        logic [11:0]      vid;
        pos = frame_pos;
        r.out_byte = b;
        if (pos < efr_pkg::POS_SRC_MAC)
            r.out_byte = filter_cfg.du_mac[8*(5-pos) +: 8];
        else if (pos < efr_pkg::POS_TYPE_HI)
        begin
            if (b != filter_cfg.ru_mac[8*(11-pos) +: 8])
                src_ok = 1'b0;
            r.out_byte = filter_cfg.own_mac[8*(11-pos) +: 8];
        end
        else if (pos == efr_pkg::POS_TYPE_HI)
            type_hi = b;
        else if (pos == efr_pkg::POS_TYPE_LO)
        begin
            if ({type_hi, b} == efr_pkg::TPID_8021Q)
                tagged_frame = 1'b1;
            else if ({type_hi, b} == efr_pkg::LOOPBACK_TYPE)
                vid_ok = 1'b0;
        end
        else if (tagged_frame && pos == efr_pkg::POS_TCI_HI)
        begin
            // keep priority and DEI, replace the top of the VID
            tci_nibble = b[3:0];
            r.out_byte = {b[7:4], filter_cfg.du_vlan_id[11:8]};
        end
        else if (tagged_frame && pos == efr_pkg::POS_TCI_LO)
        begin
            vid = {tci_nibble, b};
            if (vid != filter_cfg.du_vlan_id && vid != filter_cfg.ru_vlan_id)
                vid_ok = 1'b0;
            r.out_byte = filter_cfg.du_vlan_id[7:0];
        end
        if (pos == (tagged_frame ? efr_pkg::POS_PORT_TAG : efr_pkg::POS_PORT_UNTAG))
            port_ok = filter_cfg.port_mask[b[3:0]];
        if (pos == (tagged_frame ? efr_pkg::POS_END_TAG : efr_pkg::POS_END_UNTAG))
            hdr_done = 1'b1;
        r.out_last = last;
        r.forward  = last && hdr_done && vid_ok && src_ok && port_ok;
        if (last)
            clear_frame();
        else if (frame_pos != efr_pkg::POS_MAX)
            frame_pos = frame_pos + 5'd1;
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Queue one frame: header fields as given, the rest random, cut or padded to len bytes
    task automatic push_frame(input logic tag, input logic [11:0] vid,
                              input logic [15:0] etype, input logic [47:0] src,
                              input logic [3:0] port, input int len);
        logic [7:0] fb[$];
        frame_req_t req;
        for (int i = 0; i < 6; i++)
            fb.push_back(8'($urandom));
        for (int i = 0; i < 6; i++)
            fb.push_back(src[8*(5-i) +: 8]);
        if (tag)
        begin
            fb.push_back(efr_pkg::TPID_8021Q[15:8]);
            fb.push_back(efr_pkg::TPID_8021Q[7:0]);
            fb.push_back({4'($urandom), vid[11:8]});
            fb.push_back(vid[7:0]);
        end
        fb.push_back(etype[15:8]);
        fb.push_back(etype[7:0]);
        for (int i = 0; i < 8; i++)
            fb.push_back(i == 5 ? {4'($urandom), port} : 8'($urandom));
        while (fb.size() < len)
            fb.push_back(8'($urandom));
        for (int i = 0; i < len; i++)
        begin
            req.data = fb[i];
            req.last = (i == len - 1);
            frame_bytes_q.push_back(req);
        end
        bytes_queued += len;
    endtask

    // Mostly well-formed frames with random content; some noise and truncation
    task automatic random_frame();
        logic        tag;
        logic [11:0] vid;
        logic [15:0] etype;
        logic [47:0] src;
        int          hdr;
        int          len;
        int          pick;
        frame_req_t  req;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++)
            begin
                req.data = 8'($urandom);
                req.last = (i == len - 1);
                frame_bytes_q.push_back(req);
            end
            bytes_queued += len;
        end
        else
        begin
            tag = 1'($urandom);
            case ($urandom_range(0, 3))
                0:       vid = filter_cfg.du_vlan_id;
                1:       vid = filter_cfg.ru_vlan_id;
                2:       vid = filter_cfg.du_vlan_id;
                default: vid = 12'($urandom);
            endcase
            etype = 16'($urandom);
            if ($urandom_range(0, 9) == 0 || (tag && $urandom_range(0, 1) == 1))
                etype = efr_pkg::LOOPBACK_TYPE;
            src = filter_cfg.ru_mac;
            if ($urandom_range(0, 7) == 0)
                src = src ^ (48'd1 << $urandom_range(0, 47));
            hdr = tag ? HDR_TAG : HDR_UNTAG;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                len = $urandom_range(1, hdr - 1);
            else if (pick == 1)
                len = $urandom_range(hdr + 16, 64);
            else
                len = hdr + $urandom_range(0, 12);
            push_frame(tag, vid, etype, src, 4'($urandom), len);
        end
    endtask

    // Hold one register write until the port takes it
    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_cfg(idx, val);
    endtask

    task automatic set_phase_config(input int phase);
        logic [47:0] ru;
        logic [47:0] du;
        logic [47:0] own;
        logic [11:0] dv;
        logic [11:0] rv;
        logic [15:0] pm;
        logic [47:0] junk;
        ru   = rand48();
        du   = rand48();
        own  = rand48();
        dv   = 12'($urandom);
        rv   = 12'($urandom);
        pm   = 16'($urandom);
        junk = rand48();
        case (phase)
            0:
            begin
                ru = '0; du = '0; own = '0; dv = '0; rv = '1; pm = 16'h5555;
            end
            1:
            begin
                ru = '1; du = '1; own = '1; dv = '1; rv = '1; pm = '1;
            end
            2:       pm = '0;
            default: ;
        endcase
        cfg_write(efr_pkg::CFG_RU_MAC, ru);
        cfg_write(efr_pkg::CFG_DU_MAC, du);
        cfg_write(efr_pkg::CFG_OWN_MAC, own);
        cfg_write(efr_pkg::CFG_DU_VLAN, {junk[47:12], dv});
        cfg_write(efr_pkg::CFG_RU_VLAN, {junk[35:0], rv});
        cfg_write(efr_pkg::CFG_PORT_MASK, {junk[47:16], pm});
        if (phase % 3 == 1)
        begin
            cfg_write(CFG_SPARE_LO, rand48());
            cfg_write(CFG_SPARE_HI, rand48());
        end
        cfg_valid <= 1'b0;
    endtask

    // Wait until every request has been sent and every byte has come back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (frame_bytes_q.size() != 0 || in_valid || rewritten_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Byte driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        frame_req_t req;
        logic       take;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= 8'h00;
            last_byte  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            take = in_valid && !in_stall;
            if (take)
                rewritten_q.push_back(rewrite_byte(data_byte, last_byte));
            if (!in_valid || take)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (frame_bytes_q.size() > 0)
                begin
                    req = frame_bytes_q.pop_front();
                    in_valid  <= 1'b1;
                    data_byte <= req.data;
                    last_byte <= req.last;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output stall pattern, with a long hold on each new ticket
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          hold_left = 0;
    int          hold_seen = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive_stall
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            mode_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (hold_seen != hold_ticket)
            begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(16, 96);
                end
                mode_left--;
                case (stall_mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_TOGGLE: out_stall <= ~out_stall;
                    default:      out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Compare each delivered byte with the oldest expectation
    always @(posedge clk)
    begin : check_bytes
        efr_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rewritten_q.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, got out_byte %h",
                         $time, out_byte);
                errors++;
            end
            else
            begin
                want = rewritten_q.pop_front();
                if (out_byte !== want.out_byte)
                begin
                    $display("%0t: out_byte expected %h got %h",
                             $time, want.out_byte, out_byte);
                    errors++;
                end
                if (out_last !== want.out_last)
                begin
                    $display("%0t: out_last expected %b got %b",
                             $time, want.out_last, out_last);
                    errors++;
                end
                if (forward !== want.forward)
                begin
                    $display("%0t: forward expected %b got %b",
                             $time, want.forward, forward);
                    errors++;
                end
            end
        end
    end

    // Abort a hung run
    int cycle_count = 0;

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_ecpri_fronthaul_frame_filter_rewriter NOT OK");
            $finish;
        end
    end

    // Stimulus: configure, queue a phase of frames, drain, repeat
    initial
    begin : stimulus
        int phase_end;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_phase_config(phase);
            if (phase == 0)
            begin
                // forwarded, port bit clear, tagged loopback inner type
                push_frame(1'b0, 12'h000, 16'h0800, filter_cfg.ru_mac, 4'd0, HDR_UNTAG);
                push_frame(1'b0, 12'h000, 16'h0800, filter_cfg.ru_mac, 4'd1, HDR_UNTAG);
                push_frame(1'b1, filter_cfg.du_vlan_id, efr_pkg::LOOPBACK_TYPE,
                           filter_cfg.ru_mac, 4'd2, HDR_TAG);
                push_frame(1'b1, filter_cfg.ru_vlan_id, 16'h0800, filter_cfg.ru_mac,
                           4'd14, HDR_TAG + 4);
                // foreign VID, untagged loopback, wrong source
                push_frame(1'b1, 12'h123, 16'h0800, filter_cfg.ru_mac, 4'd6, HDR_TAG);
                push_frame(1'b0, 12'h000, efr_pkg::LOOPBACK_TYPE, filter_cfg.ru_mac, 4'd0,
                           HDR_UNTAG);
                push_frame(1'b0, 12'h000, 16'h0800, filter_cfg.ru_mac ^ 48'h1, 4'd0,
                           HDR_UNTAG);
                // short frames, one byte frame, long frame past position saturation
                push_frame(1'b0, 12'h000, 16'h0800, filter_cfg.ru_mac, 4'd0, HDR_UNTAG - 1);
                push_frame(1'b1, filter_cfg.du_vlan_id, 16'h0800, filter_cfg.ru_mac, 4'd0,
                           HDR_TAG - 1);
                push_frame(1'b0, 12'h000, 16'h0800, filter_cfg.ru_mac, 4'd0, 1);
                push_frame(1'b0, 12'h000, 16'h0800, filter_cfg.ru_mac, 4'd4, 48);
            end
            phase_end = bytes_queued + PHASE_BYTES;
            while (bytes_queued < phase_end)
                random_frame();
            // back up the output so the input side stalls
            if (phase == 2 || phase == 5)
                hold_ticket <= hold_ticket + 1;
            wait_idle();
        end
        if (errors == 0)
            $display("tb_ecpri_fronthaul_frame_filter_rewriter OK");
        else
            $display("tb_ecpri_fronthaul_frame_filter_rewriter NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/efr_pkg.sv
rtl/efr_cfg_regs.sv
rtl/efr_parser.sv
rtl/ecpri_fronthaul_frame_filter_rewriter.sv
rtl/efr_checker.sv
bench/tb_ecpri_fronthaul_frame_filter_rewriter.sv
